>>> rtl/pqdt_pkg.sv
// ----------------------------------------------------------------------------
// pqdt_pkg
// Types and constants for the product quantisation distance table lookup:
// request and response payloads, opcodes and the 48-bit saturation limits.
// ----------------------------------------------------------------------------
package pqdt_pkg;

   localparam logic [1:0] OP_CB_WRITE = 2'd0;
   localparam logic [1:0] OP_QUERY    = 2'd1;
   localparam logic [1:0] OP_CODE     = 2'd2;

   localparam logic [47:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SAT_MIN = 48'h8000_0000_0000;

   localparam logic [64:0] ROUND_HALF = 65'h0_0000_0000_0000_8000;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         dim_index;
      logic [5:0]         chunk_index;
      logic [7:0]         center_index;
      logic signed [31:0] coord_value;
      logic               first_of_chunk;
      logic               last_chunk;
   } req_type;

   typedef struct packed {
      logic signed [47:0] distance;
      logic               overflow;
   } rsp_type;

endpackage

>>> rtl/pqdt_ram.sv
// ----------------------------------------------------------------------------
// pqdt_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module pqdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pq_distance_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// pq_distance_table_lookup_unit
// Product quantisation distance engine: codebook store, per-chunk distance
// table built from query coordinates, and code byte lookup with a saturating
// running sum.
// ----------------------------------------------------------------------------
// A codebook write or a point code byte is taken while busy is low, and these
// may follow each other back to back. A query coordinate holds busy high
// while the sequencer walks every center of the chunk once through the single
// shared multiplier and the table's one read and one write port, then drains
// the operand, multiply and accumulate stages. A result appears on rsp, with
// rsp_valid high for one cycle, once the code byte that carries last_chunk
// has passed through lk_v_ff and rsp_valid_ff; the receiver cannot stall it
// and must take it in that cycle. metric_mode may only be written while busy
// is low and no lookup is in flight.
// ----------------------------------------------------------------------------
module pq_distance_table_lookup_unit
   import pqdt_pkg::*;
#(
   parameter int CENTER_COUNT = 256,
   parameter int MAX_DIMS     = 256,
   parameter int MAX_CHUNKS   = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int CW       = $clog2(CENTER_COUNT);
   localparam int CB_DEPTH = MAX_DIMS * CENTER_COUNT;
   localparam int CB_AW    = $clog2(CB_DEPTH);
   localparam int TB_DEPTH = MAX_CHUNKS * CENTER_COUNT;
   localparam int TB_AW    = $clog2(TB_DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        mode_ff;
   logic [7:0]  dim_ff;
   logic [5:0]  chunk_ff;
   logic signed [31:0] coord_ff;
   logic        first_ff;

   logic        accept;
   logic        dim_ok, chunk_ok, center_ok;

   // query pipeline
   logic        v1_ff, v2_ff, v3_ff;
   logic [CW-1:0] c1_ff, c2_ff, c3_ff;
   logic signed [32:0] op_a_ff, op_b_ff, op_a_in, op_b_in;
   logic signed [32:0] diff;
   logic signed [31:0] cv;
   logic [47:0] base2_ff, base3_ff, base_in;
   logic signed [65:0] prod_full;
   logic signed [64:0] prod_ff;
   logic [64:0] rnd;
   logic [48:0] term;
   logic [49:0] upd_sum;
   logic [47:0] upd_sat;

   // lookup path
   logic        lk_v_ff, lk_last_ff, lk_ok_ff;
   logic [47:0] entry;
   logic [48:0] run_sum;
   logic [47:0] run_sat;
   logic        run_ovf;
   logic [47:0] sum_ff;
   logic        sticky_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // memories
   logic              cb_we;
   logic [CB_AW-1:0]  cb_waddr, cb_raddr;
   logic [31:0]       cb_rdata;
   logic              tb_we;
   logic [TB_AW-1:0]  tb_waddr, tb_raddr;
   logic [47:0]       tb_rdata;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign dim_ok    = 32'(req.dim_index) < MAX_DIMS;
   assign chunk_ok  = 32'(req.chunk_index) < MAX_CHUNKS;
   assign center_ok = 32'(req.center_index) < CENTER_COUNT;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && req.opcode == OP_QUERY && dim_ok && chunk_ok) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CENTER_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         v1_ff <= (state_ff == ST_ISSUE);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.opcode == OP_QUERY) begin
         dim_ff   <= req.dim_index;
         chunk_ff <= req.chunk_index;
         coord_ff <= req.coord_value;
         first_ff <= req.first_of_chunk;
      end
   end

   // memory addressing
   assign cb_we    = accept && req.opcode == OP_CB_WRITE && dim_ok && center_ok;
   assign cb_waddr = CB_AW'(CB_AW'(req.dim_index) * CB_AW'(CENTER_COUNT)
                            + CB_AW'(req.center_index));
   assign cb_raddr = CB_AW'(CB_AW'(dim_ff) * CB_AW'(CENTER_COUNT) + CB_AW'(cnt_ff));

   assign tb_raddr = (state_ff == ST_ISSUE)
                     ? TB_AW'(TB_AW'(chunk_ff) * TB_AW'(CENTER_COUNT) + TB_AW'(cnt_ff))
                     : TB_AW'(TB_AW'(req.chunk_index) * TB_AW'(CENTER_COUNT)
                              + TB_AW'(req.center_index));
   assign tb_we    = v3_ff;
   assign tb_waddr = TB_AW'(TB_AW'(chunk_ff) * TB_AW'(CENTER_COUNT) + TB_AW'(c3_ff));

   pqdt_ram #(
      .WIDTH (32),
      .DEPTH (CB_DEPTH)
   ) u_codebook (
      .clock   (clock),
      .wr_en   (cb_we),
      .wr_addr (cb_waddr),
      .wr_data (req.coord_value),
      .rd_addr (cb_raddr),
      .rd_data (cb_rdata)
   );

   pqdt_ram #(
      .WIDTH (48),
      .DEPTH (TB_DEPTH)
   ) u_dist_table (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (tb_waddr),
      .wr_data (upd_sat),
      .rd_addr (tb_raddr),
      .rd_data (tb_rdata)
   );

   // stage 1: operands
   always_comb begin
      cv      = signed'(cb_rdata);
      diff    = {cv[31], cv} - {coord_ff[31], coord_ff};
      op_a_in = mode_ff ? {cv[31], cv} : diff;
      op_b_in = mode_ff ? {coord_ff[31], coord_ff} : diff;
      base_in = first_ff ? '0 : tb_rdata;
   end

   // stage 2: shared multiplier
   assign prod_full = op_a_ff * op_b_ff;

   // stage 3: round to q16.16, accumulate, saturate
   always_comb begin
      rnd  = prod_ff + ROUND_HALF;
      term = rnd[64:16];
      if (mode_ff) begin
         upd_sum = {{2{base3_ff[47]}}, base3_ff} - {term[48], term};
      end else begin
         upd_sum = {{2{base3_ff[47]}}, base3_ff} + {term[48], term};
      end
      if (upd_sum[49:47] == 3'b000 || upd_sum[49:47] == 3'b111) begin
         upd_sat = upd_sum[47:0];
      end else begin
         upd_sat = upd_sum[49] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff    <= cnt_ff;
      op_a_ff  <= op_a_in;
      op_b_ff  <= op_b_in;
      base2_ff <= base_in;
      c2_ff    <= c1_ff;
      prod_ff  <= prod_full[64:0];
      base3_ff <= base2_ff;
      c3_ff    <= c2_ff;
   end

   // code byte lookup and running sum
   always_comb begin
      entry   = lk_ok_ff ? tb_rdata : '0;
      run_sum = {sum_ff[47], sum_ff} + {entry[47], entry};
      run_ovf = sticky_ff;
      if (lk_ok_ff && (entry == SAT_MAX || entry == SAT_MIN)) begin
         run_ovf = 1'b1;
      end
      if (run_sum[48] != run_sum[47]) begin
         run_sat = run_sum[48] ? SAT_MIN : SAT_MAX;
         run_ovf = 1'b1;
      end else begin
         run_sat = run_sum[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_v_ff      <= 1'b0;
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lk_v_ff      <= accept && req.opcode == OP_CODE;
         rsp_valid_ff <= lk_v_ff && lk_last_ff;
         if (lk_v_ff) begin
            if (lk_last_ff) begin
               sum_ff    <= '0;
               sticky_ff <= 1'b0;
            end else begin
               sum_ff    <= run_sat;
               sticky_ff <= run_ovf;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lk_last_ff      <= req.last_chunk;
      lk_ok_ff        <= chunk_ok && center_ok;
      rsp_ff.distance <= signed'(run_sat);
      rsp_ff.overflow <= run_ovf;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // checks
   a_write_only_busy : assert property (@(posedge clock) disable iff (reset)
      tb_we |-> busy)
      else $error("table written outside a query pass");

   a_rsp_after_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(lk_v_ff && lk_last_ff))
      else $error("result without a final code byte");

   a_sum_cleared : assert property (@(posedge clock) disable iff (reset)
      (lk_v_ff && lk_last_ff) |=> (sum_ff == '0 && !sticky_ff))
      else $error("running sum not cleared after a result");

   a_drain_clean : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && cnt_ff == CW'(CENTER_COUNT - 1)) |=> state_ff == ST_DRAIN)
      else $error("sequencer left the pass early or late");

   a_no_lookup_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> !lk_v_ff || $past(state_ff == ST_IDLE))
      else $error("lookup overlapped a query pass");

endmodule
